### rtl/core/euler_to_quaternion_defines.svh
// Assertion macros shared by the euler_to_quaternion RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH
`ifndef SYNTHESIS
`define E2Q_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define E2Q_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define E2Q_ASSERT(lbl, clk, rstn, prop)
`define E2Q_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/core/e2q_pkg.sv
// Types and fixed constants for the Euler angle to quaternion converter.
// No dependencies; imported by every module of the block.
package e2q_pkg;

    localparam logic [31:0] ONE_Q     = 32'd1073741824;
    localparam logic [31:0] PI_Q      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q = 32'd1686629713;

    localparam int SERIES_CELLS = 8;
    localparam int FRONT_STAGES = 2;
    localparam int CELL_STAGES  = 3;
    localparam int MIX_STAGES   = 3;

    typedef struct packed {
        logic [31:0]        ts;
        logic [31:0]        tc;
        logic [31:0]        x2;
        logic signed [33:0] s_acc;
        logic signed [33:0] c_acc;
        logic               neg;
        logic               flip;
    } e2q_lane_t;

endpackage

### rtl/core/euler_to_quaternion.sv
// Euler angle to quaternion converter, top level. Depends on e2q_pkg and all e2q_ modules.
// The pipeline has 2 front stages, 8 series cells of 3 stages and 3 product stages.
// Throughput is one transaction per cycle while m_axis_tready stays high.
// The whole pipeline advances together; a stalled output freezes it.
// aresetn clears only the valid pipeline; data registers are not reset.
module euler_to_quaternion #(
    parameter int ANGLE_WIDTH = 16,
    parameter int QUAT_WIDTH  = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // angle_x, angle_y, angle_z, zero fill
    input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, zero fill
    output logic [((4*QUAT_WIDTH+7)/8)*8-1:0]       m_axis_tdata
);
    import e2q_pkg::*;

    `include "euler_to_quaternion_defines.svh"

    localparam int M_DW = ((4 * QUAT_WIDTH + 7) / 8) * 8;
    localparam int LAT  = FRONT_STAGES + SERIES_CELLS * CELL_STAGES + MIX_STAGES;

    logic           en;
    logic           in_acc;
    logic           out_acc;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    e2q_lane_t chain [3][SERIES_CELLS+1];

    logic [QUAT_WIDTH-1:0] qw, qx, qy, qz;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_comb begin
        vld_next = vld_reg;
        if (en) begin
            vld_next = {vld_reg[LAT-2:0], in_acc};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        e2q_front #(
            .ANGLE_WIDTH(ANGLE_WIDTH)
        ) u_front (
            .aclk    (aclk),
            .en      (en),
            .angle   ($signed(s_axis_tdata[a*ANGLE_WIDTH +: ANGLE_WIDTH])),
            .lane_out(chain[a][0])
        );
        for (genvar k = 1; k <= SERIES_CELLS; k++) begin : g_cell
            e2q_cell #(
                .K(k)
            ) u_cell (
                .aclk    (aclk),
                .en      (en),
                .lane_in (chain[a][k-1]),
                .lane_out(chain[a][k])
            );
        end
    end

    e2q_combine #(
        .QUAT_WIDTH(QUAT_WIDTH)
    ) u_combine (
        .aclk  (aclk),
        .en    (en),
        .lane_x(chain[0][SERIES_CELLS]),
        .lane_y(chain[1][SERIES_CELLS]),
        .lane_z(chain[2][SERIES_CELLS]),
        .quat_w(qw),
        .quat_x(qx),
        .quat_y(qy),
        .quat_z(qz)
    );

    assign m_axis_tdata = M_DW'({qz, qy, qx, qw});

    `E2Q_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_axis_tvalid)
    `E2Q_ASSERT(a_stall_freezes, aclk, aresetn, (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_reg))
    `E2Q_ASSERT(a_count_up, aclk, aresetn, (in_acc && !out_acc) |=> ($countones(vld_reg) == $past($countones(vld_reg)) + 1))
    `E2Q_ASSERT(a_count_down, aclk, aresetn, (out_acc && !in_acc) |=> ($countones(vld_reg) + 1 == $past($countones(vld_reg))))

endmodule

### rtl/core/e2q_front.sv
// Half-angle folding and squaring stage that starts one sine/cosine series lane.
// Depends on e2q_pkg.
module e2q_front #(
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [ANGLE_WIDTH-1:0] angle,
    output e2q_pkg::e2q_lane_t            lane_out
);
    import e2q_pkg::*;

    localparam int SHIFT = 32 - ANGLE_WIDTH;

    logic signed [31:0] half;
    logic [32:0]        mag33;
    logic [31:0]        mag;
    logic               flip;
    logic [31:0]        r_next;
    logic [63:0]        sq;
    e2q_lane_t          lane_next;

    logic [31:0]        r_reg;
    logic               neg_reg;
    logic               flip_reg;
    e2q_lane_t          lane_reg;

    always_comb begin
        half      = 32'(angle) <<< SHIFT;
        mag33     = half[31] ? (33'd0 - 33'(half)) : 33'(half);
        mag       = mag33[31:0];
        flip      = mag > HALF_PI_Q;
        r_next    = flip ? (PI_Q - mag) : mag;
        sq        = 64'(r_reg) * 64'(r_reg);
        lane_next.ts    = r_reg;
        lane_next.tc    = ONE_Q;
        lane_next.x2    = sq[61:30];
        lane_next.s_acc = $signed({2'b00, r_reg});
        lane_next.c_acc = $signed({2'b00, ONE_Q});
        lane_next.neg   = neg_reg;
        lane_next.flip  = flip_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg    <= r_next;
            neg_reg  <= half[31];
            flip_reg <= flip;
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

### rtl/core/e2q_cell.sv
// One series cell: computes the next sine and cosine terms and adds them to, or subtracts them from, the sums.
// Depends on e2q_pkg; three register stages per cell.
module e2q_cell #(
    parameter int K = 1
) (
    input  logic               aclk,
    input  logic               en,
    input  e2q_pkg::e2q_lane_t lane_in,
    output e2q_pkg::e2q_lane_t lane_out
);
    import e2q_pkg::*;

    localparam int          DS  = 2 * K * (2 * K + 1);
    localparam int          DC  = (2 * K - 1) * 2 * K;
    localparam logic [31:0] DSV = 32'(DS);
    localparam logic [31:0] DCV = 32'(DC);
    localparam logic [31:0] MS  = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] MC  = 32'((64'd1 << 32) / DC);
    localparam bit          SUB = (K % 2) == 1;

    logic [63:0] ps_prod;
    logic [63:0] pc_prod;
    logic [63:0] qs_prod;
    logic [63:0] qc_prod;
    logic [63:0] ds_prod;
    logic [63:0] dc_prod;
    logic [31:0] rs;
    logic [31:0] rc;
    logic [31:0] qs;
    logic [31:0] qc;
    e2q_lane_t   l3_next;

    e2q_lane_t   l1_reg;
    e2q_lane_t   l2_reg;
    e2q_lane_t   l3_reg;
    logic [31:0] ps1_reg;
    logic [31:0] pc1_reg;
    logic [31:0] ps2_reg;
    logic [31:0] pc2_reg;
    logic [31:0] qs2_reg;
    logic [31:0] qc2_reg;

    always_comb begin
        ps_prod = 64'(lane_in.ts) * 64'(lane_in.x2);
        pc_prod = 64'(lane_in.tc) * 64'(lane_in.x2);
        qs_prod = 64'(ps1_reg) * 64'(MS);
        qc_prod = 64'(pc1_reg) * 64'(MC);
        ds_prod = 64'(qs2_reg) * 64'(DSV);
        dc_prod = 64'(qc2_reg) * 64'(DCV);
        rs      = ps2_reg - ds_prod[31:0];
        rc      = pc2_reg - dc_prod[31:0];
        qs      = (rs >= DSV) ? (qs2_reg + 32'd1) : qs2_reg;
        qc      = (rc >= DCV) ? (qc2_reg + 32'd1) : qc2_reg;
        l3_next    = l2_reg;
        l3_next.ts = qs;
        l3_next.tc = qc;
        if (SUB) begin
            l3_next.s_acc = l2_reg.s_acc - $signed({2'b00, qs});
            l3_next.c_acc = l2_reg.c_acc - $signed({2'b00, qc});
        end else begin
            l3_next.s_acc = l2_reg.s_acc + $signed({2'b00, qs});
            l3_next.c_acc = l2_reg.c_acc + $signed({2'b00, qc});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l1_reg  <= lane_in;
            ps1_reg <= ps_prod[61:30];
            pc1_reg <= pc_prod[61:30];
            l2_reg  <= l1_reg;
            ps2_reg <= ps1_reg;
            pc2_reg <= pc1_reg;
            qs2_reg <= qs_prod[63:32];
            qc2_reg <= qc_prod[63:32];
            l3_reg  <= l3_next;
        end
    end

    assign lane_out = l3_reg;

endmodule

### rtl/core/e2q_combine.sv
// Clamps the series sums, forms the triple products and rounds the four components.
// Depends on e2q_pkg; three register stages, the last one is the output register.
module e2q_combine #(
    parameter int QUAT_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  en,
    input  e2q_pkg::e2q_lane_t    lane_x,
    input  e2q_pkg::e2q_lane_t    lane_y,
    input  e2q_pkg::e2q_lane_t    lane_z,
    output logic [QUAT_WIDTH-1:0] quat_w,
    output logic [QUAT_WIDTH-1:0] quat_x,
    output logic [QUAT_WIDTH-1:0] quat_y,
    output logic [QUAT_WIDTH-1:0] quat_z
);
    import e2q_pkg::*;

    localparam int          SH      = 32 - QUAT_WIDTH;
    localparam logic [32:0] HALF    = (33'd1 << SH) >> 1;
    localparam logic [32:0] LIM_NEG = 33'd1 << (QUAT_WIDTH - 1);
    localparam logic [32:0] LIM_POS = LIM_NEG - 33'd1;

    function automatic logic [30:0] clamp_mag(input logic signed [33:0] v);
        logic [30:0] res;
        if (v < 0) begin
            res = 31'd0;
        end else if (v > $signed({2'b00, ONE_Q})) begin
            res = ONE_Q[30:0];
        end else begin
            res = v[30:0];
        end
        return res;
    endfunction

    function automatic logic [30:0] rmul(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = 62'(a) * 62'(b) + (62'd1 << 29);
        return p[60:30];
    endfunction

    function automatic logic signed [31:0] to_signed(input logic [30:0] m, input logic s);
        logic signed [31:0] v;
        v = $signed({1'b0, m});
        return s ? -v : v;
    endfunction

    function automatic logic [QUAT_WIDTH-1:0] to_output(input logic signed [32:0] v);
        logic [32:0] m;
        logic [32:0] mr;
        logic [32:0] mm;
        m  = v[32] ? (33'd0 - $unsigned(v)) : $unsigned(v);
        mr = (m + HALF) >> SH;
        if (v[32]) begin
            mm = (mr > LIM_NEG) ? LIM_NEG : mr;
            mm = 33'd0 - mm;
        end else begin
            mm = (mr > LIM_POS) ? LIM_POS : mr;
        end
        return mm[QUAT_WIDTH-1:0];
    endfunction

    logic [30:0] sxm, cxm, sym, cym, szm, czm;
    logic signed [32:0] w_sum, x_sum, y_sum, z_sum;

    logic [30:0] cxcy_reg, sxsy_reg, sxcy_reg, cxsy_reg, cz_reg, sz_reg;
    logic        cxcy_s_reg, sxsy_s_reg, sxcy_s_reg, cxsy_s_reg, cz_s_reg, sz_s_reg;
    logic signed [31:0] w1_reg, w2_reg, x1_reg, x2_reg, y1_reg, y2_reg, z1_reg, z2_reg;
    logic [QUAT_WIDTH-1:0] qw_reg, qx_reg, qy_reg, qz_reg;

    always_comb begin
        sxm   = clamp_mag(lane_x.s_acc);
        cxm   = clamp_mag(lane_x.c_acc);
        sym   = clamp_mag(lane_y.s_acc);
        cym   = clamp_mag(lane_y.c_acc);
        szm   = clamp_mag(lane_z.s_acc);
        czm   = clamp_mag(lane_z.c_acc);
        w_sum = 33'(w1_reg) - 33'(w2_reg);
        x_sum = -33'(x1_reg) - 33'(x2_reg);
        y_sum = -33'(y1_reg) + 33'(y2_reg);
        z_sum = -33'(z1_reg) - 33'(z2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cxcy_reg   <= rmul(cxm, cym);
            sxsy_reg   <= rmul(sxm, sym);
            sxcy_reg   <= rmul(sxm, cym);
            cxsy_reg   <= rmul(cxm, sym);
            cz_reg     <= czm;
            sz_reg     <= szm;
            cxcy_s_reg <= lane_x.flip ^ lane_y.flip;
            sxsy_s_reg <= lane_x.neg ^ lane_y.neg;
            sxcy_s_reg <= lane_x.neg ^ lane_y.flip;
            cxsy_s_reg <= lane_x.flip ^ lane_y.neg;
            cz_s_reg   <= lane_z.flip;
            sz_s_reg   <= lane_z.neg;

            w1_reg <= to_signed(rmul(cxcy_reg, cz_reg), cxcy_s_reg ^ cz_s_reg);
            w2_reg <= to_signed(rmul(sxsy_reg, sz_reg), sxsy_s_reg ^ sz_s_reg);
            x1_reg <= to_signed(rmul(sxcy_reg, cz_reg), sxcy_s_reg ^ cz_s_reg);
            x2_reg <= to_signed(rmul(cxsy_reg, sz_reg), cxsy_s_reg ^ sz_s_reg);
            y1_reg <= to_signed(rmul(cxsy_reg, cz_reg), cxsy_s_reg ^ cz_s_reg);
            y2_reg <= to_signed(rmul(sxcy_reg, sz_reg), sxcy_s_reg ^ sz_s_reg);
            z1_reg <= to_signed(rmul(cxcy_reg, sz_reg), cxcy_s_reg ^ sz_s_reg);
            z2_reg <= to_signed(rmul(sxsy_reg, cz_reg), sxsy_s_reg ^ cz_s_reg);

            qw_reg <= to_output(w_sum);
            qx_reg <= to_output(x_sum);
            qy_reg <= to_output(y_sum);
            qz_reg <= to_output(z_sum);
        end
    end

    assign quat_w = qw_reg;
    assign quat_x = qx_reg;
    assign quat_y = qy_reg;
    assign quat_z = qz_reg;

endmodule

### dv/euler_to_quaternion_checker.sv
// Checker for the Euler angle to quaternion converter: watches both stream channels,
// predicts each quaternion from the accepted angles and compares it field by field.
// Depends only on the euler_to_quaternion port widths; no package functions are used.
module euler_to_quaternion_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned UNIT_Q    = 64'd1073741824;
    localparam longint unsigned PI_FIX    = 64'd3373259426;
    localparam longint unsigned HALF_PI_F = 64'd1686629713;
    localparam int              TERMS     = 9;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic signed [15:0] w;
    } quat_t;

    quat_t quat_queue[$];

    function automatic void half_trig(input longint half, output longint s_val,
                                      output longint c_val);
        longint unsigned mag, r, x2, ts, tc;
        longint          s_sum, c_sum;
        bit              neg, flip;
        neg = half < 0;
        mag = neg ? -half : half;
        flip = mag > HALF_PI_F;
        r = flip ? PI_FIX - mag : mag;
        x2 = (r * r) >> 30;
        ts = r;
        tc = UNIT_Q;
        s_sum = 0;
        c_sum = 0;
        for (int k = 0; k < TERMS; k++) begin
            if (k % 2) begin
                s_sum -= ts;
                c_sum -= tc;
            end else begin
                s_sum += ts;
                c_sum += tc;
            end
            ts = ((ts * x2) >> 30) / ((2 * k + 2) * (2 * k + 3));
            tc = ((tc * x2) >> 30) / ((2 * k + 1) * (2 * k + 2));
        end
        if (s_sum < 0) s_sum = 0;
        if (s_sum > UNIT_Q) s_sum = UNIT_Q;
        if (c_sum < 0) c_sum = 0;
        if (c_sum > UNIT_Q) c_sum = UNIT_Q;
        s_val = neg ? -s_sum : s_sum;
        c_val = flip ? -c_sum : c_sum;
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        longint unsigned ua, ub, r;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        r = (ua * ub + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [15:0] round_sat(longint v);
        longint unsigned mag;
        mag = v < 0 ? -v : v;
        mag = (mag + (64'd1 << 15)) >> 16;
        if (v < 0) begin
            if (mag > 32768) mag = 32768;
            return 16'(-longint'(mag));
        end
        if (mag > 32767) mag = 32767;
        return 16'(mag);
    endfunction

    function automatic quat_t angles_to_quat(logic [47:0] angles);
        longint sx, cx, sy, cy, sz, cz;
        quat_t  q;
        half_trig(longint'($signed(angles[15:0])) <<< 16, sx, cx);
        half_trig(longint'($signed(angles[31:16])) <<< 16, sy, cy);
        half_trig(longint'($signed(angles[47:32])) <<< 16, sz, cz);
        q.w = round_sat(fix_mul(fix_mul(cx, cy), cz) - fix_mul(fix_mul(sx, sy), sz));
        q.x = round_sat(-fix_mul(fix_mul(sx, cy), cz) - fix_mul(fix_mul(cx, sy), sz));
        q.y = round_sat(-fix_mul(fix_mul(cx, sy), cz) + fix_mul(fix_mul(sx, cy), sz));
        q.z = round_sat(-fix_mul(fix_mul(cx, cy), sz) - fix_mul(fix_mul(sx, sy), cz));
        return q;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending_count = 0;
    end

    always @(posedge aclk) begin
        quat_t got, want;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) quat_queue.push_back(angles_to_quat(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (quat_queue.size() == 0) begin
                    $display("unexpected quaternion at %0t", $realtime);
                    fail_count++;
                end else begin
                    want = quat_queue.pop_front();
                    if (got.w !== want.w) report_mismatch("quat_w", got.w, want.w);
                    if (got.x !== want.x) report_mismatch("quat_x", got.x, want.x);
                    if (got.y !== want.y) report_mismatch("quat_y", got.y, want.y);
                    if (got.z !== want.z) report_mismatch("quat_z", got.z, want.z);
                end
            end
        end
        pending_count = quat_queue.size();
    end
endmodule

### dv/tb_euler_to_quaternion.sv
// Testbench top for the Euler angle to quaternion converter: drives angle transactions
// with random idling and back-pressure and gives the verdict from the checker's counts.
// Depends on euler_to_quaternion and euler_to_quaternion_checker.
module tb_euler_to_quaternion;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;
    int          fail_count, pending_count;
    int          send_idle_pct = 22, recv_idle_pct = 77;
    bit          hold_off = 0;

    euler_to_quaternion DUT (.*);
    euler_to_quaternion_checker u_checker (.*);

    initial forever #10 aclk = ~aclk;

    initial begin
        #50ms;
        $display("euler_to_quaternion test failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_axis_tready <= 0;
        else m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
    end

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(5))
            0: return 16'($signed(25736 - int'($urandom_range(30))));
            1: return 16'(-25736 + int'($urandom_range(30)));
            2: return 16'($urandom);
            default: return 16'(int'($urandom_range(51472)) - 25736);
        endcase
    endfunction

    task automatic send_angles(input logic [47:0] angles);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= angles;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] edges[12] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                                   16'd25736, -16'sd25736, 16'd12868, -16'sd12868,
                                   16'd25735, 16'd6434, 16'h5555};
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        for (int i = 0; i < 12; i++)
            send_angles({edges[(i + 5) % 12], edges[(i + 3) % 12], edges[i]});
        for (int i = 0; i < 12; i++) send_angles({3{edges[i]}});
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 22 : phase == 1 ? 77 : 0;
            recv_idle_pct = phase == 0 ? 77 : phase == 1 ? 22 : 0;
            for (int i = 0; i < 540; i++) begin
                if (phase == 2 && i == 100) fork
                    begin
                        hold_off = 1;
                        repeat (200) @(posedge aclk);
                        hold_off = 0;
                    end
                join_none
                send_angles({rand_angle(), rand_angle(), rand_angle()});
            end
            wait_drained();
        end
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("euler_to_quaternion test passed");
        else
            $display("euler_to_quaternion test failed");
        $finish;
    end
endmodule
